// ===== rtl/signed_int_to_decimal_ascii_macros.svh =====
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SIC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define SIC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sic_pkg.sv =====
package sic_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int QDEPTH = 2;

	localparam logic [6:0] CHAR_ZERO = 7'd48;
	localparam logic [6:0] CHAR_MINUS = 7'd45;

	localparam logic [3:0] DD_LIMIT = 4'd5;
	localparam logic [3:0] DD_BIAS = 4'd3;

	function automatic int num_digits(input int w);
		return (w * 30103) / 100000 + 1;
	endfunction

	function automatic logic [3:0] dd_adjust(input logic [3:0] d);
		return (d >= DD_LIMIT) ? d + DD_BIAS : d;
	endfunction

endpackage

// ===== rtl/sic_front.sv =====
module sic_front #(
	parameter int VALUE_WIDTH = sic_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic                   q_full,
	output logic                   q_push,
	output logic [VALUE_WIDTH:0]   q_data
);

	logic                   neg;
	logic [VALUE_WIDTH-1:0] mag;

	assign neg = value[VALUE_WIDTH-1];
	assign mag = neg ? (~value + VALUE_WIDTH'(1)) : value;

	assign in_stall = q_full;
	assign q_push = in_valid && !q_full;
	assign q_data = {neg, mag};

endmodule

// ===== rtl/sic_fifo.sv =====
module sic_fifo #(
	parameter int DW = sic_pkg::VALUE_WIDTH_DEF + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wdata,
	input  logic          pop,
	output logic [DW-1:0] rdata,
	output logic          full,
	output logic          empty
);

	localparam int PW = $clog2(sic_pkg::QDEPTH);
	localparam int CW = $clog2(sic_pkg::QDEPTH + 1);

	logic [DW-1:0] mem_q [sic_pkg::QDEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full = cnt_q == CW'(sic_pkg::QDEPTH);
	assign empty = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(sic_pkg::QDEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(sic_pkg::QDEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/sic_conv.sv =====
module sic_conv #(
	parameter int VALUE_WIDTH = sic_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	output logic                   q_pop,
	input  logic [VALUE_WIDTH:0]   q_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [6:0]             text_char,
	output logic                   is_last
);

	localparam int NDIG = sic_pkg::num_digits(VALUE_WIDTH);
	localparam int BW = NDIG * 4;
	localparam int CW = $clog2(VALUE_WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                 state_q;
	logic [BW-1:0]          bcd_q;
	logic [BW-1:0]          bcd_adj;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic [CW-1:0]          cnt_q;
	logic                   neg_q;
	logic                   lead_q;
	logic                   out_valid_q;
	logic [6:0]             text_char_q;
	logic                   is_last_q;
	logic [3:0]             top;
	logic                   ofree;
	logic                   skip;
	logic                   emit;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			bcd_adj[i*4 +: 4] = sic_pkg::dd_adjust(bcd_q[i*4 +: 4]);
		end
	end

	assign top = bcd_q[BW-1 -: 4];
	assign ofree = !out_valid_q || !out_stall;
	assign skip = (state_q == ST_EMIT) && !neg_q && lead_q && (top == 4'd0) && (cnt_q != '0);
	assign emit = (state_q == ST_EMIT) && ofree && !skip;
	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			neg_q <= 1'b0;
			lead_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						neg_q <= q_data[VALUE_WIDTH];
						cnt_q <= CW'(VALUE_WIDTH - 1);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (cnt_q == '0) begin
						cnt_q <= CW'(NDIG - 1);
						lead_q <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_EMIT: begin
					if (skip) begin
						cnt_q <= cnt_q - CW'(1);
					end else if (emit) begin
						if (neg_q) begin
							neg_q <= 1'b0;
						end else begin
							lead_q <= 1'b0;
							cnt_q <= cnt_q - CW'(1);
							if (cnt_q == '0) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			mag_q <= q_data[VALUE_WIDTH-1:0];
			bcd_q <= '0;
		end else if (state_q == ST_CONV) begin
			bcd_q <= {bcd_adj[BW-2:0], mag_q[VALUE_WIDTH-1]};
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
		end else if (skip || (emit && !neg_q)) begin
			bcd_q <= {bcd_q[BW-5:0], 4'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			text_char_q <= neg_q ? sic_pkg::CHAR_MINUS : sic_pkg::CHAR_ZERO + {3'b000, top};
			is_last_q <= !neg_q && (cnt_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign text_char = text_char_q;
	assign is_last = is_last_q;

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Each item is taken from the queue and passed through the bit-serial binary-to-BCD
// shift loop; the minus sign, if any, comes first, leading zeros are then suppressed,
// and the digits follow at one character per cycle while out_stall is low. A two-entry
// queue lets the input side run ahead of the shift loop and the digit emitter.
// Reset (arst_n low) empties the queue and the output.
`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii #(
	parameter int VALUE_WIDTH = sic_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [6:0]             text_char,
	output logic                   is_last
);

	logic                 q_push;
	logic                 q_pop;
	logic                 q_full;
	logic                 q_empty;
	logic [VALUE_WIDTH:0] q_wdata;
	logic [VALUE_WIDTH:0] q_rdata;
	logic                 is_minus;
	logic                 char_ok;

	sic_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.q_full(q_full),
		.q_push(q_push),
		.q_data(q_wdata)
	);

	sic_fifo #(
		.DW(VALUE_WIDTH + 1)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.pop(q_pop),
		.rdata(q_rdata),
		.full(q_full),
		.empty(q_empty)
	);

	sic_conv #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_conv (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.q_data(q_rdata),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.text_char(text_char),
		.is_last(is_last)
	);

	assign is_minus = text_char == sic_pkg::CHAR_MINUS;
	assign char_ok = is_minus
		|| ((text_char >= sic_pkg::CHAR_ZERO) && (text_char <= sic_pkg::CHAR_ZERO + 7'd9));

	`SIC_ASSERT_NOW(a_char_range, out_valid, char_ok, "character out of range")
	`SIC_ASSERT_NOW(a_minus_not_last, out_valid && is_minus, !is_last, "minus sign flagged last")
	`SIC_ASSERT_NEXT(a_full_not_empty, q_full, !q_empty, "queue drained too fast")

endmodule
